>>> rtl/core/cnmd_pkg.sv
package cnmd_pkg;

    localparam int MAX_WIDTH   = 2048;
    localparam int MAX_HEIGHT  = 2048;
    localparam int DIM_WIDTH   = 12;
    localparam int COORD_WIDTH = 11;
    localparam int PIXEL_WIDTH = 8;
    localparam int ADDR_WIDTH  = $clog2(MAX_WIDTH);
    localparam int ROW_WIDTH   = $clog2(MAX_HEIGHT);
    localparam int EFF_W_WIDTH = (ADDR_WIDTH + 1 > DIM_WIDTH) ? ADDR_WIDTH + 1 : DIM_WIDTH;
    localparam int EFF_H_WIDTH = (ROW_WIDTH + 1 > DIM_WIDTH) ? ROW_WIDTH + 1 : DIM_WIDTH;
    localparam int LINE_BITS   = 2;

    localparam logic [DIM_WIDTH-1:0] WIDTH_RESET  = DIM_WIDTH'(640);
    localparam logic [DIM_WIDTH-1:0] HEIGHT_RESET = DIM_WIDTH'(480);

    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    localparam logic KIND_ENDING      = 1'b0;
    localparam logic KIND_BIFURCATION = 1'b1;

    localparam logic [2:0] CN_ENDING      = 3'd1;
    localparam logic [2:0] CN_BIFURCATION = 3'd3;

    typedef struct packed {
        logic                  valid;
        logic [ADDR_WIDTH-1:0] col;
        logic [ROW_WIDTH-1:0]  row;
        logic                  cur;
    } pixel_t;

    typedef struct packed {
        logic [COORD_WIDTH-1:0] column;
        logic [COORD_WIDTH-1:0] row;
        logic                   kind;
    } result_t;

    // Window bit 3k is the top, 3k+1 the middle and 3k+2 the bottom of column k.
    function automatic logic [2:0] crossing_number(input logic [8:0] w);
        logic [7:0] ring;
        logic [7:0] diff;
        logic [3:0] count;
        ring  = {w[0], w[1], w[2], w[5], w[8], w[7], w[6], w[3]};
        diff  = ring ^ {ring[6:0], ring[7]};
        count = 4'd0;
        for (int i = 0; i < 8; i++)
        begin
            count = count + {3'd0, diff[i]};
        end
        return count[3:1];
    endfunction

endpackage

>>> rtl/core/cnmd_ram.sv
module cnmd_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     write_en,
    input  logic [$clog2(DEPTH)-1:0] write_addr,
    input  logic [WIDTH-1:0]         write_data,
    input  logic [$clog2(DEPTH)-1:0] read_addr,
    output logic [WIDTH-1:0]         read_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] read_data_reg;

    always_ff @(posedge clk)
    begin
        if (write_en)
        begin
            mem[write_addr] <= write_data;
        end
        read_data_reg <= mem[read_addr];
    end

    assign read_data = read_data_reg;

endmodule

>>> rtl/core/cnmd_window.sv
module cnmd_window (
    input  logic                               clk,
    input  logic                               rst_n,
    input  cnmd_pkg::pixel_t                   pix,
    input  logic                               up,
    input  logic                               mid,
    input  logic [cnmd_pkg::EFF_W_WIDTH-1:0]   eff_width,
    input  logic [cnmd_pkg::EFF_H_WIDTH-1:0]   eff_height,
    output logic                               result_valid,
    output cnmd_pkg::result_t                  result
);

    logic [8:0]                         window_reg;
    logic [8:0]                         window_next;
    logic [2:0]                         cn;
    logic [cnmd_pkg::EFF_W_WIDTH-1:0]   col_ext;
    logic [cnmd_pkg::EFF_H_WIDTH-1:0]   row_ext;
    logic                               interior;

    assign window_next = {pix.cur, mid, up, window_reg[8:3]};
    assign cn          = cnmd_pkg::crossing_number(window_next);
    assign col_ext     = cnmd_pkg::EFF_W_WIDTH'(pix.col);
    assign row_ext     = cnmd_pkg::EFF_H_WIDTH'(pix.row);

    assign interior = (col_ext >= cnmd_pkg::EFF_W_WIDTH'(2))
                   && (col_ext <= eff_width - cnmd_pkg::EFF_W_WIDTH'(1))
                   && (row_ext >= cnmd_pkg::EFF_H_WIDTH'(2))
                   && (row_ext <= eff_height - cnmd_pkg::EFF_H_WIDTH'(1));

    assign result_valid = pix.valid && interior && window_next[4]
                       && ((cn == cnmd_pkg::CN_ENDING) || (cn == cnmd_pkg::CN_BIFURCATION));

    assign result.column = cnmd_pkg::COORD_WIDTH'(col_ext - cnmd_pkg::EFF_W_WIDTH'(1));
    assign result.row    = cnmd_pkg::COORD_WIDTH'(row_ext - cnmd_pkg::EFF_H_WIDTH'(1));
    assign result.kind   = (cn == cnmd_pkg::CN_BIFURCATION) ? cnmd_pkg::KIND_BIFURCATION
                                                            : cnmd_pkg::KIND_ENDING;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= 9'd0;
        end
        else if (pix.valid)
        begin
            window_reg <= window_next;
        end
    end

endmodule

>>> rtl/core/cnmd_out_buffer.sv
module cnmd_out_buffer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  cnmd_pkg::result_t push_data,
    input  logic              out_stall,
    output logic              out_valid,
    output cnmd_pkg::result_t out_data,
    output logic [1:0]        level_after
);

    logic              head_valid_reg;
    logic              head_valid_next;
    cnmd_pkg::result_t head_data_reg;
    cnmd_pkg::result_t head_data_next;
    logic              skid_valid_reg;
    logic              skid_valid_next;
    cnmd_pkg::result_t skid_data_reg;
    cnmd_pkg::result_t skid_data_next;
    logic              take;
    logic              head_free;

    assign take      = head_valid_reg && !out_stall;
    assign head_free = !head_valid_reg || take;

    // Entries still held once this cycle's word has been taken.
    assign level_after = {1'b0, head_valid_reg} + {1'b0, skid_valid_reg} - {1'b0, take};

    always_comb
    begin
        head_valid_next = head_valid_reg;
        head_data_next  = head_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (head_free)
        begin
            if (skid_valid_reg)
            begin
                head_valid_next = 1'b1;
                head_data_next  = skid_data_reg;
                skid_valid_next = push;
                skid_data_next  = push_data;
            end
            else
            begin
                head_valid_next = push;
                head_data_next  = push_data;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_data_reg <= head_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = head_valid_reg;
    assign out_data  = head_data_reg;

endmodule

>>> rtl/core/crossing_number_minutiae_detect.sv
// Crossing-number minutiae detector. Pixels of a binarized image arrive in raster order, one
// word per pixel, and are taken at one pixel per clock while pixel_stall is low; a minutia
// found at a pixel appears on the output once the pixel that completes its 3x3 window has
// passed the stage register and the output buffer's head register, or later when the output
// is stalled. Two previous rows live in one line memory of MAX_WIDTH entries, read and written
// once per pixel; that single read-modify-write sets the rate of one pixel per clock. Reset
// clears it one entry per cycle with pixel_stall high; configuration writes are taken meanwhile.
module crossing_number_minutiae_detect (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic                               cfg_index,
    input  logic [cnmd_pkg::DIM_WIDTH-1:0]     cfg_data,
    input  logic                               pixel_valid,
    output logic                               pixel_stall,
    input  logic [cnmd_pkg::PIXEL_WIDTH-1:0]   pixel_value,
    input  logic                               start_of_frame,
    output logic                               point_valid,
    input  logic                               point_stall,
    output logic [cnmd_pkg::COORD_WIDTH-1:0]   point_column,
    output logic [cnmd_pkg::COORD_WIDTH-1:0]   point_row,
    output logic                               minutia_kind
);

    logic [cnmd_pkg::DIM_WIDTH-1:0]   width_reg;
    logic [cnmd_pkg::DIM_WIDTH-1:0]   height_reg;
    logic [cnmd_pkg::EFF_W_WIDTH-1:0] width_ext;
    logic [cnmd_pkg::EFF_H_WIDTH-1:0] height_ext;
    logic [cnmd_pkg::EFF_W_WIDTH-1:0] eff_width;
    logic [cnmd_pkg::EFF_H_WIDTH-1:0] eff_height;

    logic                             clear_active_reg;
    logic [cnmd_pkg::ADDR_WIDTH-1:0]  clear_addr_reg;

    logic [cnmd_pkg::ADDR_WIDTH-1:0]  col_reg;
    logic [cnmd_pkg::ADDR_WIDTH-1:0]  col_next;
    logic [cnmd_pkg::ROW_WIDTH-1:0]   row_reg;
    logic [cnmd_pkg::ROW_WIDTH-1:0]   row_next;
    logic [cnmd_pkg::ADDR_WIDTH-1:0]  col_cur;
    logic [cnmd_pkg::ROW_WIDTH-1:0]   row_cur;
    logic                             accept;

    cnmd_pkg::pixel_t                 stage_reg;
    cnmd_pkg::pixel_t                 stage_next;
    logic                             fwd_hit_reg;
    logic                             fwd_hit_next;
    logic [cnmd_pkg::LINE_BITS-1:0]   fwd_data_reg;

    logic [cnmd_pkg::LINE_BITS-1:0]   ram_read_data;
    logic [cnmd_pkg::LINE_BITS-1:0]   line_bits;
    logic [cnmd_pkg::LINE_BITS-1:0]   stage_write_data;
    logic                             ram_write_en;
    logic [cnmd_pkg::ADDR_WIDTH-1:0]  ram_write_addr;
    logic [cnmd_pkg::LINE_BITS-1:0]   ram_write_data;

    logic                             result_valid;
    cnmd_pkg::result_t                result;
    cnmd_pkg::result_t                out_data;
    logic [1:0]                       level_after;

    assign width_ext  = cnmd_pkg::EFF_W_WIDTH'(width_reg);
    assign height_ext = cnmd_pkg::EFF_H_WIDTH'(height_reg);

    always_comb
    begin
        if (width_ext < cnmd_pkg::EFF_W_WIDTH'(3))
        begin
            eff_width = cnmd_pkg::EFF_W_WIDTH'(3);
        end
        else if (width_ext > cnmd_pkg::EFF_W_WIDTH'(cnmd_pkg::MAX_WIDTH))
        begin
            eff_width = cnmd_pkg::EFF_W_WIDTH'(cnmd_pkg::MAX_WIDTH);
        end
        else
        begin
            eff_width = width_ext;
        end
        if (height_ext < cnmd_pkg::EFF_H_WIDTH'(3))
        begin
            eff_height = cnmd_pkg::EFF_H_WIDTH'(3);
        end
        else if (height_ext > cnmd_pkg::EFF_H_WIDTH'(cnmd_pkg::MAX_HEIGHT))
        begin
            eff_height = cnmd_pkg::EFF_H_WIDTH'(cnmd_pkg::MAX_HEIGHT);
        end
        else
        begin
            eff_height = height_ext;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= cnmd_pkg::WIDTH_RESET;
            height_reg <= cnmd_pkg::HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                cnmd_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                cnmd_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default:                    width_reg  <= width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_active_reg <= 1'b1;
            clear_addr_reg   <= '0;
        end
        else if (clear_active_reg)
        begin
            clear_addr_reg <= clear_addr_reg + cnmd_pkg::ADDR_WIDTH'(1);
            if (clear_addr_reg == cnmd_pkg::ADDR_WIDTH'(cnmd_pkg::MAX_WIDTH - 1))
            begin
                clear_active_reg <= 1'b0;
            end
        end
    end

    // A pixel is taken only when its possible result is sure to find room in the output buffer.
    assign pixel_stall = clear_active_reg
                      || ({1'b0, level_after} + {2'b00, stage_reg.valid} > 3'd1);
    assign accept      = pixel_valid && !pixel_stall;

    assign col_cur = start_of_frame ? '0 : col_reg;
    assign row_cur = start_of_frame ? '0 : row_reg;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (cnmd_pkg::EFF_W_WIDTH'(col_cur) >= eff_width - cnmd_pkg::EFF_W_WIDTH'(1))
            begin
                col_next = '0;
                if (cnmd_pkg::EFF_H_WIDTH'(row_cur) >= eff_height - cnmd_pkg::EFF_H_WIDTH'(1))
                begin
                    row_next = '0;
                end
                else
                begin
                    row_next = row_cur + cnmd_pkg::ROW_WIDTH'(1);
                end
            end
            else
            begin
                col_next = col_cur + cnmd_pkg::ADDR_WIDTH'(1);
                row_next = row_cur;
            end
        end
    end

    // The entry written by the pixel in flight is not yet visible to a read of the same column
    // issued in the same cycle, so its new contents are forwarded.
    assign stage_write_data = {line_bits[0], stage_reg.cur};
    assign fwd_hit_next     = accept && stage_reg.valid && (stage_reg.col == col_cur);

    assign stage_next.valid = accept;
    assign stage_next.col   = col_cur;
    assign stage_next.row   = row_cur;
    assign stage_next.cur   = (pixel_value != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            stage_reg   <= '0;
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            stage_reg   <= stage_next;
            fwd_hit_reg <= fwd_hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= stage_write_data;
    end

    assign line_bits = fwd_hit_reg ? fwd_data_reg : ram_read_data;

    assign ram_write_en   = clear_active_reg || stage_reg.valid;
    assign ram_write_addr = clear_active_reg ? clear_addr_reg : stage_reg.col;
    assign ram_write_data = clear_active_reg ? '0 : stage_write_data;

    cnmd_ram #(
        .WIDTH (cnmd_pkg::LINE_BITS),
        .DEPTH (cnmd_pkg::MAX_WIDTH)
    ) u_line_ram (
        .clk        (clk),
        .write_en   (ram_write_en),
        .write_addr (ram_write_addr),
        .write_data (ram_write_data),
        .read_addr  (col_cur),
        .read_data  (ram_read_data)
    );

    cnmd_window u_window (
        .clk          (clk),
        .rst_n        (rst_n),
        .pix          (stage_reg),
        .up           (line_bits[1]),
        .mid          (line_bits[0]),
        .eff_width    (eff_width),
        .eff_height   (eff_height),
        .result_valid (result_valid),
        .result       (result)
    );

    cnmd_out_buffer u_out_buffer (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (result_valid),
        .push_data   (result),
        .out_stall   (point_stall),
        .out_valid   (point_valid),
        .out_data    (out_data),
        .level_after (level_after)
    );

    assign point_column = out_data.column;
    assign point_row    = out_data.row;
    assign minutia_kind = out_data.kind;

endmodule

>>> rtl/core/cnmd_checker.sv
module cnmd_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               pixel_valid,
    input logic                               pixel_stall,
    input logic                               point_valid,
    input logic                               point_stall,
    input logic [cnmd_pkg::COORD_WIDTH-1:0]   point_column,
    input logic [cnmd_pkg::COORD_WIDTH-1:0]   point_row,
    input logic                               minutia_kind
);

    // A stalled word holds until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && point_stall |=> point_valid && $stable(point_column)
            && $stable(point_row) && $stable(minutia_kind))
    else $error("stalled output word changed");

    // A word appearing on an empty output comes from a taken pixel, through the stage register and the buffer head.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(point_valid) |-> $past(pixel_valid && !pixel_stall, 2))
    else $error("output word without a matching input pixel");

    // Pixels in the top row or the left column never give a minutia.
    assert property (@(posedge clk) disable iff (!rst_n)
        point_valid |-> (point_column != '0) && (point_row != '0))
    else $error("minutia reported on the image border");

endmodule

bind crossing_number_minutiae_detect cnmd_checker u_cnmd_checker (.*);
